FILE: rtl/core/cfbs_pkg.sv
// cfbs_pkg: shared constants, codes and types for the circular FIFO with search.
// Used by cfbs_search and circular_fifo_with_binary_search; no dependencies.
`timescale 1ns / 1ps

package cfbs_pkg;

    // Built depth of the word store
    localparam int DEPTH   = 256;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int WORD_W  = 32;
    localparam int CAP_W   = 9;
    localparam int SLOT_W  = 8;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CAP_RST = 256;

    // Operation codes (s_axis_tuser)
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SRCH = 2'd2;

    // Result status codes (m_axis_tuser)
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_state;

    // Sequencer -> search unit
    typedef struct packed {
        logic start;   // load bounds and key
        logic probe;   // latch midpoint and its slot
        logic cmp;     // narrow bounds from read word
    } t_srch_ctl;

    // Search unit -> sequencer
    typedef struct packed {
        logic range_empty;  // lo >= hi
        logic hit;          // read word equals key
    } t_srch_sts;

endpackage

FILE: rtl/core/cfbs_ram.sv
// cfbs_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cfbs_ram #(
    parameter int W = 32,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cfbs_search.sv
// cfbs_search: binary-search bounds, midpoint-to-slot mapping and key compare.
// Depends on cfbs_pkg; stepped by the sequencer in the top level.
`timescale 1ns / 1ps

module cfbs_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cfbs_pkg::t_srch_ctl           i_ctl,
    input  logic [cfbs_pkg::CNT_W-1:0]    i_count,
    input  logic [cfbs_pkg::ADDR_W-1:0]   i_head,
    input  logic [cfbs_pkg::CNT_W-1:0]    i_cap,
    input  logic [cfbs_pkg::WORD_W-1:0]   i_key,
    input  logic [cfbs_pkg::WORD_W-1:0]   i_rdata,
    output cfbs_pkg::t_srch_sts           o_sts,
    output logic [cfbs_pkg::ADDR_W-1:0]   o_phys,
    output logic [cfbs_pkg::ADDR_W-1:0]   o_slot
);

    logic [cfbs_pkg::CNT_W-1:0]  r_lo, r_hi, r_mid;
    logic [cfbs_pkg::ADDR_W-1:0] r_phys;
    logic [cfbs_pkg::WORD_W-1:0] r_key;

    logic [cfbs_pkg::CNT_W-1:0]  mid;
    logic [cfbs_pkg::SUM_W-1:0]  sum;
    logic [cfbs_pkg::SUM_W-1:0]  sum_wrap;
    logic                        w_lt;

    // head < cap and mid < cap, so one subtract folds the sum back in range
    always_comb begin
        mid      = r_lo + ((r_hi - r_lo) >> 1);
        sum      = cfbs_pkg::SUM_W'(i_head) + cfbs_pkg::SUM_W'(mid);
        sum_wrap = (sum >= cfbs_pkg::SUM_W'(i_cap)) ? (sum - cfbs_pkg::SUM_W'(i_cap)) : sum;
        o_phys   = cfbs_pkg::ADDR_W'(sum_wrap);
        w_lt     = $signed(i_rdata) < $signed(r_key);
    end

    assign o_sts.range_empty = (r_lo >= r_hi);
    assign o_sts.hit         = (i_rdata == r_key);
    assign o_slot            = r_phys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_ctl.start) begin
            r_lo <= '0;
            r_hi <= i_count;
        end else if (i_ctl.cmp) begin
            if (w_lt) begin
                r_lo <= r_mid + 1'b1;
            end else begin
                r_hi <= r_mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_key <= i_key;
        end
        if (i_ctl.probe) begin
            r_mid  <= mid;
            r_phys <= o_phys;
        end
    end

endmodule

FILE: rtl/core/circular_fifo_with_binary_search.sv
// Circular FIFO of signed 32-bit words with push, pop and binary search; uses cfbs_pkg,
// cfbs_ram, cfbs_search. From the accepting edge to m_axis_tvalid a push passes DONE, a pop
// POP then DONE, a search PROBE and CMP per probe (one more PROBE on a miss) then DONE, with
// P probes <= ceil(log2(count+1)). One word at a time: s_axis_tready returns with m_axis_tvalid
// when the output register is free, and DONE holds until it is.
// Reset (i_rst_n low, synchronous): queue empty, pointers zero, capacity 256 (DEPTH max).
`timescale 1ns / 1ps

module circular_fifo_with_binary_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: capacity
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] data, [39:32] slot
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------

    // capacity: zero reads as one, above the built depth saturates
    function automatic logic [cfbs_pkg::CNT_W-1:0] lim_cap(
        input logic [cfbs_pkg::CAP_W-1:0] v
    );
        int c;
        c = int'(v);
        if (c == 0) c = 1;
        if (c > cfbs_pkg::DEPTH) c = cfbs_pkg::DEPTH;
        return cfbs_pkg::CNT_W'(c);
    endfunction

    // ring increment modulo the programmed capacity
    function automatic logic [cfbs_pkg::ADDR_W-1:0] next_slot(
        input logic [cfbs_pkg::ADDR_W-1:0] p,
        input logic [cfbs_pkg::CNT_W-1:0]  cap
    );
        logic [cfbs_pkg::SUM_W-1:0] s;
        s = cfbs_pkg::SUM_W'(p) + 1'b1;
        if (s >= cfbs_pkg::SUM_W'(cap)) s = '0;
        return cfbs_pkg::ADDR_W'(s);
    endfunction

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    cfbs_pkg::t_state r_state, n_state;

    logic [cfbs_pkg::ADDR_W-1:0] r_head, n_head;
    logic [cfbs_pkg::ADDR_W-1:0] r_ws, n_ws;
    logic [cfbs_pkg::CNT_W-1:0]  r_count, n_count;
    logic [cfbs_pkg::CNT_W-1:0]  r_cap, n_cap;

    // pending result, then output register (decouples the sink)
    logic [cfbs_pkg::STAT_W-1:0] r_res_status, n_res_status;
    logic [cfbs_pkg::WORD_W-1:0] r_res_data, n_res_data;
    logic [cfbs_pkg::SLOT_W-1:0] r_res_slot, n_res_slot;

    logic                        r_out_valid, n_out_valid;
    logic [cfbs_pkg::STAT_W-1:0] r_out_status, n_out_status;
    logic [cfbs_pkg::WORD_W-1:0] r_out_data, n_out_data;
    logic [cfbs_pkg::SLOT_W-1:0] r_out_slot, n_out_slot;

    // store and search unit hookup
    logic                        ram_we;
    logic [cfbs_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [cfbs_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

    cfbs_pkg::t_srch_ctl         srch_ctl;
    cfbs_pkg::t_srch_sts         srch_sts;
    logic [cfbs_pkg::ADDR_W-1:0] srch_phys, srch_slot;

    logic s_accept;
    logic out_free;

    assign s_axis_tready = (r_state == cfbs_pkg::S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // ---------------------------------------------------------------
    // Word store
    // ---------------------------------------------------------------
    cfbs_ram #(
        .W (cfbs_pkg::WORD_W),
        .D (cfbs_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Search unit: bounds, midpoint slot, compare
    // ---------------------------------------------------------------
    cfbs_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (srch_ctl),
        .i_count (r_count),
        .i_head  (r_head),
        .i_cap   (r_cap),
        .i_key   (s_axis_tdata),
        .i_rdata (ram_rdata),
        .o_sts   (srch_sts),
        .o_phys  (srch_phys),
        .o_slot  (srch_slot)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfbs_pkg::S_IDLE;
            r_head      <= '0;
            r_ws        <= '0;
            r_count     <= '0;
            r_cap       <= lim_cap(cfbs_pkg::CAP_W'(cfbs_pkg::CAP_RST));
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_ws        <= n_ws;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_slot   <= n_out_slot;
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_ws         = r_ws;
        n_count      = r_count;
        n_cap        = r_cap;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_slot   = r_out_slot;

        ram_we    = 1'b0;
        ram_waddr = r_ws;
        ram_wdata = s_axis_tdata;
        ram_raddr = r_head;
        srch_ctl  = '0;

        case (r_state)
            cfbs_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_res_status = cfbs_pkg::ST_OK;
                    n_res_data   = '0;
                    n_res_slot   = '0;
                    n_state      = cfbs_pkg::S_DONE;
                    case (s_axis_tuser)
                        cfbs_pkg::MODE_PUSH: begin
                            if (r_count >= r_cap) begin
                                n_res_status = cfbs_pkg::ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_ws    = next_slot(r_ws, r_cap);
                                n_count = r_count + 1'b1;
                            end
                        end
                        cfbs_pkg::MODE_POP: begin
                            if (r_count == '0) begin
                                n_res_status = cfbs_pkg::ST_EMPTY;
                            end else begin
                                // read of the head slot lands next cycle
                                n_head  = next_slot(r_head, r_cap);
                                n_count = r_count - 1'b1;
                                n_state = cfbs_pkg::S_POP;
                            end
                        end
                        cfbs_pkg::MODE_SRCH: begin
                            if (r_count == '0) begin
                                n_res_status = cfbs_pkg::ST_EMPTY;
                            end else begin
                                srch_ctl.start = 1'b1;
                                n_state        = cfbs_pkg::S_PROBE;
                            end
                        end
                        default: begin
                            // unused mode: no-op, zero result
                        end
                    endcase
                end
            end

            cfbs_pkg::S_POP: begin
                n_res_data = ram_rdata;
                n_state    = cfbs_pkg::S_DONE;
            end

            cfbs_pkg::S_PROBE: begin
                if (srch_sts.range_empty) begin
                    n_res_status = cfbs_pkg::ST_MISS;
                    n_state      = cfbs_pkg::S_DONE;
                end else begin
                    srch_ctl.probe = 1'b1;
                    ram_raddr      = srch_phys;
                    n_state        = cfbs_pkg::S_CMP;
                end
            end

            cfbs_pkg::S_CMP: begin
                if (srch_sts.hit) begin
                    n_res_status = cfbs_pkg::ST_OK;
                    n_res_slot   = cfbs_pkg::SLOT_W'(srch_slot);
                    n_state      = cfbs_pkg::S_DONE;
                end else begin
                    srch_ctl.cmp = 1'b1;
                    n_state      = cfbs_pkg::S_PROBE;
                end
            end

            cfbs_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = r_res_data;
                    n_out_slot   = r_res_slot;
                    n_state      = cfbs_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = cfbs_pkg::S_IDLE;
            end
        endcase

        // capacity write empties the queue; the user must issue it only while idle, the block does not enforce this
        if (i_cfg_we) begin
            n_cap   = lim_cap(i_cfg_wdata);
            n_head  = '0;
            n_ws    = '0;
            n_count = '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_slot, r_out_data};
    assign m_axis_tuser  = r_out_status;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`ifndef SYNTHESIS
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("queue count above capacity");

    a_ptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfbs_pkg::SUM_W'(r_head) < cfbs_pkg::SUM_W'(r_cap)) &&
        (cfbs_pkg::SUM_W'(r_ws) < cfbs_pkg::SUM_W'(r_cap)))
        else $error("ring pointer outside capacity");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (s_axis_tuser == cfbs_pkg::MODE_POP) && (r_count != '0) && !i_cfg_we)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not remove one word");
`endif

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for circular_fifo_with_binary_search (push, pop, search, capacity).
// Depends on cfbs_pkg and the RTL below rtl/core; everything else is generated here.
`timescale 1ns / 1ps

module tb;

    // Mode 3 has no name in the package; the block must treat it as a no-op.
    localparam logic [cfbs_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 24;   // beyond the longest search word
    localparam int N_PHASES      = 8;

    // One input word: operation plus value/key
    typedef struct {
        logic [cfbs_pkg::MODE_W-1:0] mode;
        logic [cfbs_pkg::WORD_W-1:0] value;
    } t_op_word;

    // One result word as the block should report it
    typedef struct {
        logic [cfbs_pkg::STAT_W-1:0] status;
        logic [cfbs_pkg::WORD_W-1:0] data;
        logic [cfbs_pkg::SLOT_W-1:0] slot;
    } t_fifo_result;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_cfg_we      = 1'b0;
    logic [cfbs_pkg::CAP_W-1:0] i_cfg_wdata   = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [31:0]                s_axis_tdata  = '0;   // [31:0] value
    logic [1:0]                 s_axis_tuser  = '0;   // [1:0] mode
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [39:0]                m_axis_tdata;         // [31:0] data, [39:32] slot
    logic [1:0]                 m_axis_tuser;         // [1:0] status

    circular_fifo_with_binary_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ---------------------------------------------------------------
    // Queue model: ring of words, pointers wrap at the live capacity.
    // ---------------------------------------------------------------
    logic [cfbs_pkg::WORD_W-1:0] ring_mem [cfbs_pkg::DEPTH];
    int ring_head, ring_tail, ring_count, ring_cap;

    t_fifo_result fifo_replies_q [$];   // predicted results, oldest first
    t_op_word     op_backlog [$];       // words waiting for the driver
    t_op_word     cur_op;               // word currently offered on s_axis

    // stimulus-side view of the queue, used only to steer the random mix
    logic [cfbs_pkg::WORD_W-1:0] gen_words [$];
    int     gen_cap;
    longint run_val;

    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    int src_gap, snk_hold;
    int cycle_cnt, n_err, n_cfg;
    int n_push, n_full, n_pop, n_empty_pop, n_srch, n_found, n_miss, n_empty_srch, n_nop;

    // zero and oversize writes are clamped into 1..DEPTH
    function automatic int cap_effective(input logic [cfbs_pkg::CAP_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > cfbs_pkg::DEPTH)
            return cfbs_pkg::DEPTH;
        return int'(v);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Applies one accepted word to the model and returns the result it causes.
    function automatic t_fifo_result fifo_apply(input t_op_word op);
        t_fifo_result r;
        int  lo, hi, mid, phys;
        bit  hunting;
        r.status = cfbs_pkg::ST_OK;
        r.data   = '0;
        r.slot   = '0;
        case (op.mode)
            cfbs_pkg::MODE_PUSH: begin
                n_push++;
                if (ring_count >= ring_cap) begin
                    r.status = cfbs_pkg::ST_FULL;
                    n_full++;
                end else begin
                    ring_mem[ring_tail] = op.value;
                    ring_tail = (ring_tail + 1 >= ring_cap) ? 0 : ring_tail + 1;
                    ring_count++;
                end
            end
            cfbs_pkg::MODE_POP: begin
                n_pop++;
                if (ring_count == 0) begin
                    r.status = cfbs_pkg::ST_EMPTY;
                    n_empty_pop++;
                end else begin
                    r.data = ring_mem[ring_head];
                    ring_head = (ring_head + 1 >= ring_cap) ? 0 : ring_head + 1;
                    ring_count--;
                end
            end
            cfbs_pkg::MODE_SRCH: begin
                n_srch++;
                if (ring_count == 0) begin
                    r.status = cfbs_pkg::ST_EMPTY;
                    n_empty_srch++;
                end else begin
                    // half-open [lo, hi) over logical positions, head first
                    lo = 0;
                    hi = ring_count;
                    hunting = 1'b1;
                    r.status = cfbs_pkg::ST_MISS;
                    while (hunting && lo < hi) begin
                        mid  = lo + (hi - lo) / 2;
                        phys = (ring_head + mid) % ring_cap;
                        if (ring_mem[phys] == op.value) begin
                            r.status = cfbs_pkg::ST_OK;
                            r.slot   = phys[cfbs_pkg::SLOT_W-1:0];
                            hunting  = 1'b0;
                        end else if ($signed(ring_mem[phys]) < $signed(op.value)) begin
                            lo = mid + 1;
                        end else begin
                            hi = mid;
                        end
                    end
                    if (r.status == cfbs_pkg::ST_OK)
                        n_found++;
                    else
                        n_miss++;
                end
            end
            default: begin
                n_nop++;   // no-op: zero result, state untouched
            end
        endcase
        return r;
    endfunction

    // Queue a word for the driver and track its effect on the stimulus view.
    task automatic queue_op(input logic [cfbs_pkg::MODE_W-1:0] mode,
                            input logic [cfbs_pkg::WORD_W-1:0] value);
        t_op_word w;
        w.mode  = mode;
        w.value = value;
        op_backlog.push_back(w);
        if (mode == cfbs_pkg::MODE_PUSH && gen_words.size() < gen_cap)
            gen_words.push_back(value);
        else if (mode == cfbs_pkg::MODE_POP && gen_words.size() > 0)
            void'(gen_words.pop_front());
    endtask

    // Block until nothing is offered or outstanding, then let the pipe settle.
    task automatic wait_drained();
        while (op_backlog.size() != 0 || s_axis_tvalid || fifo_replies_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Capacity write; also empties the queue in the block and in the model.
    task automatic write_capacity(input logic [cfbs_pkg::CAP_W-1:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        ring_cap   = cap_effective(v);
        ring_head  = 0;
        ring_tail  = 0;
        ring_count = 0;
        gen_cap    = ring_cap;
        gen_words.delete();
        n_cfg++;
    endtask

    // Random words in fill and drain stretches so the queue swings full <-> empty.
    // Pushes mostly climb from a random base so searches see sorted contents.
    task automatic random_phase(input int n_ops);
        int     seg_left, w_push, w_pop, r, idx;
        bit     filling;
        logic [cfbs_pkg::WORD_W-1:0] v;
        longint nxt;
        filling  = 1'b1;
        seg_left = gen_cap * 3 / 2 + 24;
        repeat (n_ops) begin
            if (seg_left == 0) begin
                filling  = !filling;
                seg_left = $urandom_range(gen_cap / 2 + 8, gen_cap * 3 / 2 + 24);
            end
            seg_left--;
            w_push = filling ? 85 : 15;
            w_pop  = filling ? 6 : 55;
            r = $urandom_range(0, 99);
            if (r < 2) begin
                queue_op(MODE_NOP, $urandom);
            end else if (r < 2 + w_push) begin
                if ($urandom_range(0, 19) == 0) begin
                    v = $urandom;   // out-of-order noise
                end else begin
                    if (gen_words.size() == 0)
                        run_val = int'($urandom);
                    if ($urandom_range(0, 3) == 0)
                        nxt = run_val;   // duplicate word
                    else
                        nxt = run_val + longint'($urandom_range(1, 1 << $urandom_range(1, 18)));
                    if (nxt > 64'sh7FFF_FFFF)
                        nxt = 64'sh7FFF_FFFF;
                    run_val = nxt;
                    v = nxt[cfbs_pkg::WORD_W-1:0];
                end
                queue_op(cfbs_pkg::MODE_PUSH, v);
            end else if (r < 2 + w_push + w_pop) begin
                queue_op(cfbs_pkg::MODE_POP, $urandom);
            end else begin
                r = $urandom_range(0, 9);
                if (gen_words.size() > 0) begin
                    idx = $urandom_range(0, gen_words.size() - 1);
                    if (r < 6)
                        v = gen_words[idx];                       // should hit
                    else if (r < 8)
                        v = gen_words[idx] + ((r == 6) ? 32'd1 : -32'd1);  // near miss
                    else
                        v = $urandom;
                end else begin
                    v = $urandom;
                end
                queue_op(cfbs_pkg::MODE_SRCH, v);
            end
        end
    endtask

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run-length guard
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, fifo_replies_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Driver: offers words from op_backlog, predicts each one at acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                fifo_replies_q.push_back(fifo_apply(cur_op));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (op_backlog.size() > 0) begin
                    cur_op = op_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_op.value;
                    s_axis_tuser  <= cur_op.mode;
                    src_gap = src_idle_on ? draw_gap() : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure, compares each result with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_fifo_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_hold = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (fifo_replies_q.size() == 0) begin
                    $error("result word with none predicted: status %0d data %0d slot %0d",
                           m_axis_tuser, $signed(m_axis_tdata[31:0]), m_axis_tdata[39:32]);
                    n_err++;
                end else begin
                    want = fifo_replies_q.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, m_axis_tuser);
                        n_err++;
                    end
                    if (m_axis_tdata[31:0] !== want.data) begin
                        $error("data mismatch: expected %0d, got %0d",
                               $signed(want.data), $signed(m_axis_tdata[31:0]));
                        n_err++;
                    end
                    if (m_axis_tdata[39:32] !== want.slot) begin
                        $error("slot mismatch: expected %0d, got %0d",
                               want.slot, m_axis_tdata[39:32]);
                        n_err++;
                    end
                end
            end
            if (snk_hold > 0) begin
                snk_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (snk_idle_on && $urandom_range(0, 3) == 0)
                    snk_hold = draw_gap();
            end
        end
    end

    // Stimulus sequence
    initial begin : stimulus
        logic [cfbs_pkg::CAP_W-1:0] cap_plan [N_PHASES];
        int p;
        // reset state: empty queue, capacity at its reset value
        ring_cap   = cap_effective(cfbs_pkg::CAP_RST);
        ring_head  = 0;
        ring_tail  = 0;
        ring_count = 0;
        gen_cap    = ring_cap;
        run_val    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty cases, no-op, signed extremes at full capacity
        queue_op(cfbs_pkg::MODE_POP,  32'h0000_0000);
        queue_op(cfbs_pkg::MODE_SRCH, 32'h0000_0000);
        queue_op(MODE_NOP,            32'hFFFF_FFFF);
        queue_op(cfbs_pkg::MODE_PUSH, 32'h8000_0000);
        queue_op(cfbs_pkg::MODE_PUSH, 32'hFFFF_FFFF);
        queue_op(cfbs_pkg::MODE_PUSH, 32'h0000_0000);
        queue_op(cfbs_pkg::MODE_PUSH, 32'h0000_0001);
        queue_op(cfbs_pkg::MODE_PUSH, 32'h7FFF_FFFF);
        queue_op(cfbs_pkg::MODE_SRCH, 32'h8000_0000);
        queue_op(cfbs_pkg::MODE_SRCH, 32'h7FFF_FFFF);
        queue_op(cfbs_pkg::MODE_SRCH, 32'h0000_0000);
        queue_op(cfbs_pkg::MODE_SRCH, 32'hFFFF_FFFE);
        queue_op(cfbs_pkg::MODE_POP,  32'h0000_0000);
        queue_op(cfbs_pkg::MODE_SRCH, 32'h8000_0000);   // popped word is gone now

        // zero capacity acts as one slot: second push is full
        write_capacity(9'd0);
        queue_op(cfbs_pkg::MODE_PUSH, 32'd7);
        queue_op(cfbs_pkg::MODE_PUSH, 32'd8);
        queue_op(cfbs_pkg::MODE_SRCH, 32'd7);
        queue_op(cfbs_pkg::MODE_SRCH, 32'd8);
        queue_op(cfbs_pkg::MODE_POP,  32'd0);
        queue_op(cfbs_pkg::MODE_POP,  32'd0);

        // two slots: tail wraps, search must map logical to physical slot
        write_capacity(9'd2);
        queue_op(cfbs_pkg::MODE_PUSH, 32'd10);
        queue_op(cfbs_pkg::MODE_PUSH, 32'd20);
        queue_op(cfbs_pkg::MODE_POP,  32'd0);
        queue_op(cfbs_pkg::MODE_PUSH, 32'd30);
        queue_op(cfbs_pkg::MODE_SRCH, 32'd30);
        queue_op(cfbs_pkg::MODE_SRCH, 32'd20);
        queue_op(cfbs_pkg::MODE_PUSH, 32'd40);

        // random phases over several capacities, oversize writes among them
        cap_plan = '{9'd511, 9'd17, 9'd256, 9'd1, 9'd300, 9'd3, 9'd100, 9'd0};
        cap_plan[N_PHASES-1] = cfbs_pkg::CAP_W'($urandom_range(1, 511));
        for (p = 0; p < N_PHASES; p++) begin
            // each capacity write drains first, so no word is in flight when the queue is emptied
            write_capacity(cap_plan[p]);
            src_idle_on = (p == 0) || (p != 2 && $urandom_range(0, 3) != 0);
            snk_idle_on = (p == 0) || (p != 2 && $urandom_range(0, 3) != 0);
            random_phase((cap_effective(cap_plan[p]) >= 100) ? 340 : 140);
        end

        wait_drained();
        $display("covered %0d words across %0d capacity writes:",
                 n_push + n_pop + n_srch + n_nop, n_cfg);
        $display("  %0d push (%0d full), %0d pop (%0d empty), %0d no-op words",
                 n_push, n_full, n_pop, n_empty_pop, n_nop);
        $display("  searches %0d: %0d found, %0d missed, %0d on empty",
                 n_srch, n_found, n_miss, n_empty_srch);
        if (n_err == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
